>>> src/tdwc_pkg.sv
`default_nettype none

package tdwc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int WEIGHT_W    = 4;
    localparam int THRESH_W    = 12;
    localparam int TICKS_W     = 16;
    localparam int MIN_SAMPLES = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_UP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_DOWN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_LEFT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_RIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS = 3'd5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd1;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd2;
    localparam logic [TICKS_W-1:0]  TICKS_RESET  = 16'd100;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        STATUS_EMIT = 2'd0,
        STATUS_FEW  = 2'd1,
        STATUS_LOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_up;
        logic [WEIGHT_W-1:0] weight_down;
        logic [WEIGHT_W-1:0] weight_left;
        logic [WEIGHT_W-1:0] weight_right;
        logic [THRESH_W-1:0] threshold;
        logic [TICKS_W-1:0]  window_ticks;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/tdwc_cfg_regs.sv
`default_nettype none

module tdwc_cfg_regs
    import tdwc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WEIGHT_UP:    cfg_next.weight_up    = cfg_wdata[WEIGHT_W-1:0];
                REG_WEIGHT_DOWN:  cfg_next.weight_down  = cfg_wdata[WEIGHT_W-1:0];
                REG_WEIGHT_LEFT:  cfg_next.weight_left  = cfg_wdata[WEIGHT_W-1:0];
                REG_WEIGHT_RIGHT: cfg_next.weight_right = cfg_wdata[WEIGHT_W-1:0];
                REG_THRESHOLD:    cfg_next.threshold    = cfg_wdata[THRESH_W-1:0];
                REG_WINDOW_TICKS: cfg_next.window_ticks = cfg_wdata[TICKS_W-1:0];
                default:          cfg_next = cfg_reg;   // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.weight_up    <= WEIGHT_RESET;
            cfg_reg.weight_down  <= WEIGHT_RESET;
            cfg_reg.weight_left  <= WEIGHT_RESET;
            cfg_reg.weight_right <= WEIGHT_RESET;
            cfg_reg.threshold    <= THRESH_RESET;
            cfg_reg.window_ticks <= TICKS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/tdwc_window.sv
`default_nettype none

module tdwc_window
    import tdwc_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step_en,
    input  wire logic                       kind,
    input  wire logic [1:0]                 direction,
    input  wire logic [TICKS_W-1:0]         window_ticks,
    output logic                            window_close,
    output logic [3:0][COUNT_WIDTH-1:0]     counts
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [3:0][COUNT_WIDTH-1:0] counts_reg;
    logic [3:0][COUNT_WIDTH-1:0] counts_next;
    logic                        open_reg;
    logic                        open_next;
    logic [TICKS_W-1:0]          elapsed_reg;
    logic [TICKS_W-1:0]          elapsed_next;
    logic [TICKS_W-1:0]          elapsed_inc;
    logic [TICKS_W-1:0]          limit;

    // zero length behaves as one tick
    assign limit       = (window_ticks == '0) ? TICKS_W'(1) : window_ticks;
    assign elapsed_inc = elapsed_reg + TICKS_W'(1);

    always_comb begin
        counts_next  = counts_reg;
        open_next    = open_reg;
        elapsed_next = elapsed_reg;
        window_close = 1'b0;
        if (step_en) begin
            if (kind == KIND_EDGE) begin
                if (!open_reg) begin
                    counts_next  = '0;
                    open_next    = 1'b1;
                    elapsed_next = '0;
                end
                for (int i = 0; i < 4; i++) begin
                    if (direction == 2'(i) && counts_next[i] != COUNT_MAX) begin
                        counts_next[i] = counts_next[i] + COUNT_WIDTH'(1);
                    end
                end
            end else if (open_reg) begin
                if (elapsed_inc >= limit) begin
                    open_next    = 1'b0;
                    elapsed_next = '0;
                    window_close = 1'b1;
                end else begin
                    elapsed_next = elapsed_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg  <= '0;
            open_reg    <= 1'b0;
            elapsed_reg <= '0;
        end else begin
            counts_reg  <= counts_next;
            open_reg    <= open_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // counts are unchanged by ticks, so the closing tick sees the window totals
    assign counts = counts_reg;

endmodule

`default_nettype wire

>>> src/tdwc_classify.sv
`default_nettype none

module tdwc_classify
    import tdwc_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic [3:0][COUNT_WIDTH-1:0] counts,
    input  cfg_t                             cfg,
    output dir_t                             chosen,
    output status_t                          status
);

    localparam int PROD_W = COUNT_WIDTH + WEIGHT_W;
    localparam int CMP_W  = (PROD_W > THRESH_W) ? PROD_W : THRESH_W;

    logic [3:0][CMP_W-1:0] weighted;
    logic [CMP_W-1:0]      thresh_ext;
    logic                  enough;
    logic [1:0]            best_idx;
    logic [CMP_W-1:0]      best_val;

    assign weighted[0] = CMP_W'(counts[0]) * CMP_W'(cfg.weight_up);
    assign weighted[1] = CMP_W'(counts[1]) * CMP_W'(cfg.weight_down);
    assign weighted[2] = CMP_W'(counts[2]) * CMP_W'(cfg.weight_left);
    assign weighted[3] = CMP_W'(counts[3]) * CMP_W'(cfg.weight_right);
    assign thresh_ext  = CMP_W'(cfg.threshold);

    always_comb begin
        enough = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (counts[i] >= COUNT_WIDTH'(MIN_SAMPLES)) begin
                enough = 1'b1;
            end
        end
    end

    // ties favor the later direction: right > left > down > up
    always_comb begin
        best_idx = 2'd0;
        best_val = weighted[0];
        for (int i = 1; i < 4; i++) begin
            if (weighted[i] >= best_val) begin
                best_idx = 2'(i);
                best_val = weighted[i];
            end
        end
    end

    always_comb begin
        chosen = DIR_UP;
        if (!enough) begin
            status = STATUS_FEW;
        end else if (best_val >= thresh_ext) begin
            status = STATUS_EMIT;
            chosen = dir_t'(best_idx);
        end else begin
            status = STATUS_LOW;
        end
    end

endmodule

`default_nettype wire

>>> src/trackball_direction_window_classifier_unit.sv
`default_nettype none

// Channel     | Handshake        | Payload
// ------------+------------------+--------------------------------------------
// input       | s_valid/s_ready  | s_kind (edge/tick), s_direction
// result      | m_valid/m_ready  | m_chosen_direction, m_window_status
// config      | cfg_wr_en        | cfg_index, cfg_wdata (no read-back)
//
// One transaction per cycle in and out while m_ready stays high. An accepted
// transaction lands in the input register; when the processing stage advances,
// the window state updates and, on a closing tick, the classifier result is
// loaded into the output register, which drives m_valid. Reset (aresetn,
// synchronous) restores register defaults and closes the window. A stalled
// output holds the input register; s_ready drops only when both are full and
// m_ready is low.

module trackball_direction_window_classifier_unit
    import tdwc_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_kind,
    input  wire logic [1:0]             s_direction,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_chosen_direction,
    output logic [1:0]                  m_window_status,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg;

    // input register
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [1:0] in_dir_reg;

    // output register
    logic       out_valid_reg;
    logic [1:0] out_dir_reg;
    logic [1:0] out_status_reg;

    logic                        advance;
    logic                        step_en;
    logic                        window_close;
    logic [3:0][COUNT_WIDTH-1:0] counts;
    dir_t                        chosen;
    status_t                     status;

    // the processing stage moves whenever the output slot is free or draining
    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    tdwc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tdwc_window #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .kind         (in_kind_reg),
        .direction    (in_dir_reg),
        .window_ticks (cfg.window_ticks),
        .window_close (window_close),
        .counts       (counts)
    );

    tdwc_classify #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_classify (
        .counts (counts),
        .cfg    (cfg),
        .chosen (chosen),
        .status (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_kind_reg <= s_kind;
            in_dir_reg  <= s_direction;
        end
    end

    // only closing ticks produce a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_en && window_close;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && window_close) begin
            out_dir_reg    <= chosen;
            out_status_reg <= status;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_chosen_direction = out_dir_reg;
    assign m_window_status    = out_status_reg;

endmodule

`default_nettype wire
